/* sv/lsg_pkg.sv */
// Shared types, constants and the color temperature table for the LED strip frame generator.
`default_nettype none
package lsg_pkg;

    localparam int LED_W = 6;

    localparam logic [31:0] HEAD_WORD   = 32'h0000_0000;
    localparam logic [31:0] END_FRAME   = 32'hffff_ffff;
    localparam logic [2:0]  LED_MARK    = 3'b111;
    localparam logic [7:0]  ROM_LAST    = 8'd254;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_LED,
        KIND_END
    } t_kind;

    typedef struct packed {
        logic             valid;
        t_kind            kind;
        logic [LED_W-1:0] led;
        logic [7:0]       color_index;
        logic [4:0]       brightness;
        logic [LED_W-1:0] pos;
    } t_issue;

    // {blue, green, red}
    localparam logic [23:0] CT_ROM [0:254] = '{
        24'h006cff, 24'h006eff, 24'h0070ff, 24'h0071ff, 24'h0073ff, 24'h0074ff, 24'h0076ff,
        24'h0077ff, 24'h0079ff, 24'h007aff, 24'h007cff, 24'h007dff, 24'h007eff, 24'h0080ff,
        24'h0081ff, 24'h0082ff, 24'h0084ff, 24'h0385ff, 24'h0786ff, 24'h0a88ff, 24'h0e89ff,
        24'h118aff, 24'h158bff, 24'h188dff, 24'h1b8eff, 24'h1e8fff, 24'h2190ff, 24'h2491ff,
        24'h2792ff, 24'h2a93ff, 24'h2d95ff, 24'h3096ff, 24'h3297ff, 24'h3598ff, 24'h3799ff,
        24'h3a9aff, 24'h3d9bff, 24'h3f9cff, 24'h419dff, 24'h449eff, 24'h469fff, 24'h48a0ff,
        24'h4ba1ff, 24'h4da2ff, 24'h4fa3ff, 24'h51a4ff, 24'h53a5ff, 24'h55a6ff, 24'h57a7ff,
        24'h59a8ff, 24'h5ba9ff, 24'h5da9ff, 24'h5faaff, 24'h61abff, 24'h63acff, 24'h65adff,
        24'h67aeff, 24'h69afff, 24'h6ab0ff, 24'h6cb0ff, 24'h6eb1ff, 24'h70b2ff, 24'h71b3ff,
        24'h73b4ff, 24'h75b4ff, 24'h76b5ff, 24'h78b6ff, 24'h7ab7ff, 24'h7bb8ff, 24'h7db8ff,
        24'h7eb9ff, 24'h80baff, 24'h81bbff, 24'h83bbff, 24'h84bcff, 24'h86bdff, 24'h87beff,
        24'h89beff, 24'h8abfff, 24'h8bc0ff, 24'h8dc1ff, 24'h8ec1ff, 24'h90c2ff, 24'h91c3ff,
        24'h92c3ff, 24'h94c4ff, 24'h95c5ff, 24'h96c5ff, 24'h97c6ff, 24'h99c7ff, 24'h9ac7ff,
        24'h9bc8ff, 24'h9dc9ff, 24'h9ec9ff, 24'h9fcaff, 24'ha0cbff, 24'ha1cbff, 24'ha3ccff,
        24'ha4cdff, 24'ha5cdff, 24'ha6ceff, 24'ha7ceff, 24'ha8cfff, 24'haad0ff, 24'habd0ff,
        24'hacd1ff, 24'hadd1ff, 24'haed2ff, 24'hafd3ff, 24'hb0d3ff, 24'hb1d4ff, 24'hb2d4ff,
        24'hb3d5ff, 24'hb4d6ff, 24'hb5d6ff, 24'hb6d7ff, 24'hb7d7ff, 24'hb8d8ff, 24'hb9d8ff,
        24'hbad9ff, 24'hbbdaff, 24'hbcdaff, 24'hbddbff, 24'hbedbff, 24'hbfdcff, 24'hc0dcff,
        24'hc1ddff, 24'hc2ddff, 24'hc3deff, 24'hc4deff, 24'hc5dfff, 24'hc6dfff, 24'hc7e0ff,
        24'hc8e0ff, 24'hc9e1ff, 24'hcae1ff, 24'hcae2ff, 24'hcbe3ff, 24'hcce3ff, 24'hcde4ff,
        24'hcee4ff, 24'hcfe5ff, 24'hd0e5ff, 24'hd1e5ff, 24'hd1e6ff, 24'hd2e6ff, 24'hd3e7ff,
        24'hd4e7ff, 24'hd5e8ff, 24'hd6e8ff, 24'hd6e9ff, 24'hd7e9ff, 24'hd8eaff, 24'hd9eaff,
        24'hdaebff, 24'hdaebff, 24'hdbecff, 24'hdcecff, 24'hddedff, 24'hddedff, 24'hdeedff,
        24'hdfeeff, 24'he0eeff, 24'he1efff, 24'he1efff, 24'he2f0ff, 24'he3f0ff, 24'he4f1ff,
        24'he4f1ff, 24'he5f1ff, 24'he6f2ff, 24'he6f2ff, 24'he7f3ff, 24'he8f3ff, 24'he9f4ff,
        24'he9f4ff, 24'heaf4ff, 24'hebf5ff, 24'hebf5ff, 24'hecf6ff, 24'hedf6ff, 24'heef7ff,
        24'heef7ff, 24'heff7ff, 24'hf0f8ff, 24'hf0f8ff, 24'hf1f9ff, 24'hf2f9ff, 24'hf2f9ff,
        24'hf3faff, 24'hf4faff, 24'hf4fbff, 24'hf5fbff, 24'hf6fbff, 24'hf6fcff, 24'hf7fcff,
        24'hf8fdff, 24'hf8fdff, 24'hf9fdff, 24'hf9feff, 24'hfafeff, 24'hfbfeff, 24'hfbffff,
        24'hfcffff, 24'hffffff, 24'hfffbff, 24'hfffaff, 24'hfff9ff, 24'hfff9fe, 24'hfff8fd,
        24'hfff7fc, 24'hfff7fb, 24'hfff6fa, 24'hfff6f9, 24'hfff5f8, 24'hfff5f7, 24'hfff4f6,
        24'hfff4f5, 24'hfff3f4, 24'hfff3f3, 24'hfff2f3, 24'hfff2f2, 24'hfff1f1, 24'hfff1f0,
        24'hfff0f0, 24'hfff0ef, 24'hfff0ee, 24'hffefed, 24'hffefed, 24'hffeeec, 24'hffeeec,
        24'hffeeeb, 24'hffedea, 24'hffedea, 24'hffede9, 24'hffece9, 24'hffece8, 24'hffece7,
        24'hffebe7, 24'hffebe6, 24'hffebe6, 24'hffebe5, 24'hffeae5, 24'hffeae4, 24'hffeae4,
        24'hffe9e3, 24'hffe9e3, 24'hffe9e3, 24'hffe9e2, 24'hffe8e2, 24'hffe8e1, 24'hffe8e1,
        24'hffe8e0, 24'hffe7e0, 24'hffe7e0
    };

    function automatic logic [23:0] color_rom(input logic [7:0] idx);
        return CT_ROM[idx];
    endfunction

endpackage
`default_nettype wire

/* sv/lsg_if.sv */
// Command and frame stream interfaces of the LED strip frame generator.
`default_nettype none
interface lsg_cmd_if;
    logic       valid;
    logic       ready;
    logic [7:0] color_index;
    logic [4:0] brightness;
    logic [5:0] peak_pos;

    modport source(output valid, color_index, brightness, peak_pos, input ready);
    modport sink(input valid, color_index, brightness, peak_pos, output ready);
endinterface

interface lsg_frame_if;
    logic        valid;
    logic        ready;
    logic [31:0] frame;
    logic        last;

    modport source(output valid, frame, last, input ready);
    modport sink(input valid, frame, last, output ready);
endinterface
`default_nettype wire

/* sv/lsg_scale.sv */
// Rounded scaling of one color byte by a gradient weight over the strip length.
`default_nettype none
module lsg_scale #(
    parameter int NUM_LEDS = 60
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_en,
    input  wire logic [7:0]                       i_c,
    input  wire logic [$clog2(NUM_LEDS+1)-1:0]    i_w,
    output logic      [7:0]                       o_q
);
    import lsg_pkg::*;

    localparam int WW = $clog2(NUM_LEDS + 1);
    localparam int PW = 8 + WW;
    localparam int SH = 20;
    localparam logic [SH-1:0] RECIP = SH'((1 << SH) / NUM_LEDS);

    logic [PW-1:0]    r_p;
    logic [PW-1:0]    r_p2;
    logic [7:0]       r_q0;
    logic [PW-1:0]    n_p;
    logic [PW+SH-1:0] n_prod;
    logic [PW-1:0]    qn;
    logic [PW-1:0]    rem;

    assign n_p    = PW'(i_c) * PW'(i_w) + PW'(NUM_LEDS / 2);
    assign n_prod = (PW+SH)'(r_p) * (PW+SH)'(RECIP);

    // Estimate is exact or one low; fix it with one compare and add
    assign qn  = PW'(r_q0) * PW'(NUM_LEDS);
    assign rem = r_p2 - qn;
    assign o_q = (rem >= PW'(NUM_LEDS)) ? r_q0 + 8'd1 : r_q0;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p  <= n_p;
            r_q0 <= n_prod[SH +: 8];
            r_p2 <= r_p;
        end
    end

endmodule
`default_nettype wire

/* sv/lsg_seq.sv */
// Command intake and frame sequencer: issues start, LED and end frames one per cycle while i_en is high.
`default_nettype none
module lsg_seq #(
    parameter int NUM_LEDS = 60
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    lsg_cmd_if.sink       i_cmd,
    output lsg_pkg::t_issue o_iss
);
    import lsg_pkg::*;

    localparam int CW = $clog2(NUM_LEDS + 2);
    localparam logic [CW-1:0] LAST_CNT = CW'(NUM_LEDS + 1);
    localparam logic [LED_W-1:0] POS_MAX = LED_W'(NUM_LEDS - 1);

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [7:0]       r_color;
    logic [4:0]       r_bri;
    logic [LED_W-1:0] r_pos;
    logic             accept;
    logic             at_last;

    assign at_last     = (r_cnt == LAST_CNT);
    assign i_cmd.ready = i_rst_n && i_en && (!r_busy || at_last);
    assign accept      = i_cmd.valid && i_cmd.ready;

    always_comb begin
        o_iss.valid       = r_busy;
        o_iss.led         = LED_W'(r_cnt - CW'(1));
        o_iss.color_index = r_color;
        o_iss.brightness  = r_bri;
        o_iss.pos         = r_pos;
        if (r_cnt == '0) begin
            o_iss.kind = KIND_START;
        end else if (at_last) begin
            o_iss.kind = KIND_END;
        end else begin
            o_iss.kind = KIND_LED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_en) begin
            if (accept) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy && at_last) begin
                r_busy <= 1'b0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    // Saturate the color index and clamp the peak onto the strip
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_color <= (i_cmd.color_index > ROM_LAST) ? ROM_LAST : i_cmd.color_index;
            r_bri   <= i_cmd.brightness;
            r_pos   <= (i_cmd.peak_pos > POS_MAX) ? POS_MAX : i_cmd.peak_pos;
        end
    end

endmodule
`default_nettype wire

/* sv/lsg_shade.sv */
// Shading pipeline: table lookup and weight, scaling of three bytes, frame register.
`default_nettype none
module lsg_shade #(
    parameter int NUM_LEDS = 60
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire lsg_pkg::t_issue i_iss,
    output logic                 o_en,
    lsg_frame_if.source          o_frm
);
    import lsg_pkg::*;

    localparam int WW = $clog2(NUM_LEDS + 1);

    logic             r1_valid, r2_valid, r3_valid;
    t_kind            r1_kind, r2_kind, r3_kind;
    logic [4:0]       r1_bri, r2_bri, r3_bri;
    logic [7:0]       r1_red, r1_green, r1_blue;
    logic [WW-1:0]    r1_w;
    logic             r_valid;
    logic [31:0]      r_frame;
    logic             r_last;
    logic [23:0]      base;
    logic [LED_W-1:0] span;
    logic [7:0]       q_red, q_green, q_blue;
    logic [31:0]      n_frame;

    // Whole pipeline advances together; it holds while the output is stalled
    assign o_en = !r_valid || o_frm.ready;

    assign base = color_rom(i_iss.color_index);
    assign span = (i_iss.pos > i_iss.led) ? i_iss.pos - i_iss.led : i_iss.led - i_iss.pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r_valid  <= 1'b0;
        end else if (o_en) begin
            r1_valid <= i_iss.valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r_valid  <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r1_kind  <= i_iss.kind;
            r1_bri   <= i_iss.brightness;
            r1_red   <= base[7:0];
            r1_green <= base[15:8];
            r1_blue  <= base[23:16];
            r1_w     <= WW'(NUM_LEDS) - WW'(span);
            r2_kind  <= r1_kind;
            r2_bri   <= r1_bri;
            r3_kind  <= r2_kind;
            r3_bri   <= r2_bri;
            r_frame  <= n_frame;
            r_last   <= (r3_kind == KIND_END);
        end
    end

    lsg_scale #(.NUM_LEDS(NUM_LEDS)) u_scale_red (
        .i_clk(i_clk), .i_en(o_en), .i_c(r1_red), .i_w(r1_w), .o_q(q_red)
    );
    lsg_scale #(.NUM_LEDS(NUM_LEDS)) u_scale_green (
        .i_clk(i_clk), .i_en(o_en), .i_c(r1_green), .i_w(r1_w), .o_q(q_green)
    );
    lsg_scale #(.NUM_LEDS(NUM_LEDS)) u_scale_blue (
        .i_clk(i_clk), .i_en(o_en), .i_c(r1_blue), .i_w(r1_w), .o_q(q_blue)
    );

    always_comb begin
        case (r3_kind)
            KIND_START: n_frame = HEAD_WORD;
            KIND_END:   n_frame = END_FRAME;
            KIND_LED:   n_frame = {LED_MARK, r3_bri, q_blue, q_green, q_red};
            default:    n_frame = HEAD_WORD;
        endcase
    end

    assign o_frm.valid = r_valid;
    assign o_frm.frame = r_frame;
    assign o_frm.last  = r_last;

endmodule
`default_nettype wire

/* sv/led_strip_gradient_frame_generator.sv */
// Top level of the LED strip gradient frame generator.
// Path: a start frame passes the r1, r2 and r3 stages and the frame register to o_frm.
// Throughput: one frame per cycle while o_frm is not stalled; a command yields
// NUM_LEDS+2 frames; the sequencer's frame counter takes a new one when idle or on the end frame.
// Reset: synchronous, active low; clears the sequencer and all pipeline valid bits.
`default_nettype none
module led_strip_gradient_frame_generator #(
    parameter int NUM_LEDS = 60
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    lsg_cmd_if.sink     i_cmd,
    lsg_frame_if.source o_frm
);
    import lsg_pkg::*;

    t_issue iss;
    logic   en;

    lsg_seq #(.NUM_LEDS(NUM_LEDS)) u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_cmd(i_cmd), .o_iss(iss)
    );

    lsg_shade #(.NUM_LEDS(NUM_LEDS)) u_shade (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_iss(iss), .o_en(en), .o_frm(o_frm)
    );

    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frm.valid && o_frm.last |-> o_frm.frame == END_FRAME)
        else $error("last frame is not the end frame");

    a_stall_blocks_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frm.valid && !o_frm.ready |-> !i_cmd.ready)
        else $error("command taken while output stalled");

    a_one_cmd_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid && i_cmd.ready |=> !i_cmd.ready)
        else $error("command taken while previous one still sequencing");

endmodule
`default_nettype wire

/* tb/sv/lsg_frame_checker.sv */
// Checker for the LED strip frame generator: predicts each command's strip words and compares.
module lsg_frame_checker #(
    parameter int NUM_LEDS = 60
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lsg_cmd_if        i_cmd,
    lsg_frame_if      i_frm,
    output int        o_fail_count,
    output int        o_pending
);
    import lsg_pkg::*;

    typedef struct packed {
        logic [31:0] frame;
        logic        last;
    } t_strip_word;

    t_strip_word strip_words_q[$];
    int          mismatches = 0;

    // Rounded c * weight / NUM_LEDS.
    function automatic logic [7:0] dim_level(input logic [7:0] level, input int unsigned weight);
        int unsigned scaled;
        scaled = (level * weight + NUM_LEDS / 2) / NUM_LEDS;
        return scaled[7:0];
    endfunction

    task automatic queue_render(input logic [7:0] color_index, input logic [4:0] brightness,
                                input logic [5:0] peak_raw);
        logic [7:0]  idx;
        int          peak;
        int          gap;
        int unsigned weight;
        logic [23:0] bgr;
        logic [7:0]  top;
        t_strip_word word;
        // Saturate the table index and clamp the peak to the last LED.
        idx  = (color_index > ROM_LAST) ? ROM_LAST : color_index;
        peak = (int'(peak_raw) > NUM_LEDS - 1) ? NUM_LEDS - 1 : int'(peak_raw);
        bgr  = CT_ROM[idx];
        top  = {LED_MARK, brightness};
        word.frame = HEAD_WORD;
        word.last  = 1'b0;
        strip_words_q.push_back(word);
        for (int led = 0; led < NUM_LEDS; led++) begin
            gap    = (peak > led) ? peak - led : led - peak;
            weight = NUM_LEDS - gap;
            word.frame = {top, dim_level(bgr[23:16], weight), dim_level(bgr[15:8], weight),
                          dim_level(bgr[7:0], weight)};
            word.last  = 1'b0;
            strip_words_q.push_back(word);
        end
        word.frame = END_FRAME;
        word.last  = 1'b1;
        strip_words_q.push_back(word);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        $display("MISMATCH at %0t: %s: expected %h, got %h", $time, what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_strip_word want;
        if (i_rst_n) begin
            // Pop before push so a stray frame is never matched to a fresh command.
            if (i_frm.valid && i_frm.ready) begin
                if (strip_words_q.size() == 0) begin
                    report_mismatch("frame with nothing pending", 32'h0, i_frm.frame);
                end else begin
                    want = strip_words_q.pop_front();
                    if (i_frm.frame !== want.frame)
                        report_mismatch("frame", want.frame, i_frm.frame);
                    if (i_frm.last !== want.last)
                        report_mismatch("last", 32'(want.last), 32'(i_frm.last));
                end
            end
            if (i_cmd.valid && i_cmd.ready)
                queue_render(i_cmd.color_index, i_cmd.brightness, i_cmd.peak_pos);
        end
        o_fail_count <= mismatches;
        o_pending    <= strip_words_q.size();
    end

endmodule

/* tb/sv/led_strip_gradient_frame_generator_tb.sv */
// Testbench top for the LED strip gradient frame generator: stimulus, watchdog and verdict.
module led_strip_gradient_frame_generator_tb;
    import lsg_pkg::*;

    localparam int NUM_LEDS       = 60;
    localparam int RANDOM_RENDERS = 213;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 40;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic calm    = 1'b0;
    int   fail_count;
    int   pending;
    int   quiet_cycles = 0;

    lsg_cmd_if   cmd_bus ();
    lsg_frame_if frm_bus ();

    led_strip_gradient_frame_generator #(
        .NUM_LEDS(NUM_LEDS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_bus),
        .o_frm  (frm_bus)
    );

    lsg_frame_checker #(
        .NUM_LEDS(NUM_LEDS)
    ) frame_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_bus),
        .i_frm       (frm_bus),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #4 i_clk = ~i_clk;

    // Stall the frame sink now and then, except during the calm stretch.
    initial begin
        frm_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            frm_bus.ready <= calm || ($urandom_range(0, 99) >= 9);
        end
    end

    always @(posedge i_clk) begin
        if ((cmd_bus.valid && cmd_bus.ready) || (frm_bus.valid && frm_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Drive one command and hold it until the transaction completes.
    task automatic send_render(input logic [7:0] color_index, input logic [4:0] brightness,
                               input logic [5:0] peak);
        while (!calm && $urandom_range(0, 99) < 9) begin
            cmd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_bus.valid       <= 1'b1;
        cmd_bus.color_index <= color_index;
        cmd_bus.brightness  <= brightness;
        cmd_bus.peak_pos    <= peak;
        do @(posedge i_clk); while (!cmd_bus.ready);
    endtask

    initial begin
        cmd_bus.valid       = 1'b0;
        cmd_bus.color_index = '0;
        cmd_bus.brightness  = '0;
        cmd_bus.peak_pos    = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Table ends, saturated index, clamped peaks, brightness extremes.
        send_render(8'd0,   5'd0,  6'd0);
        send_render(8'd254, 5'd31, 6'd59);
        send_render(8'd255, 5'd31, 6'd63);
        send_render(8'd255, 5'd0,  6'd60);
        send_render(8'd127, 5'd16, 6'd30);
        send_render(8'd0,   5'd31, 6'd63);
        send_render(8'd254, 5'd0,  6'd0);
        send_render(8'd1,   5'd1,  6'd1);
        send_render(8'd170, 5'd21, 6'd42);
        send_render(8'd85,  5'd10, 6'd21);
        send_render(8'd200, 5'd5,  6'd58);
        send_render(8'd31,  5'd15, 6'd61);
        send_render(8'd224, 5'd30, 6'd62);
        send_render(8'd17,  5'd8,  6'd59);
        send_render(8'd239, 5'd27, 6'd0);
        send_render(8'd100, 5'd31, 6'd1);
        send_render(8'd255, 5'd31, 6'd59);

        for (int k = 0; k < RANDOM_RENDERS; k++) begin
            calm = (k >= 100) && (k < 140);
            send_render(8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                        6'($urandom_range(0, 63)));
        end
        calm = 1'b0;
        cmd_bus.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
sv/lsg_pkg.sv
sv/lsg_if.sv
sv/lsg_scale.sv
sv/lsg_seq.sv
sv/lsg_shade.sv
sv/led_strip_gradient_frame_generator.sv
tb/sv/lsg_frame_checker.sv
tb/sv/led_strip_gradient_frame_generator_tb.sv
